### design/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg: shared definitions for the bilinear RGB sampler
// Field widths, command and register codes, and parameter defaults.
// ----------------------------------------------------------------------------
package brs_pkg;

  // payload widths fixed by the interface
  localparam int CMD_W   = 1;
  localparam int COORD_W = 9;
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int POS_W   = 20;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 1;

  // commands
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // size register value after reset
  localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 8;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

endpackage

### design/bilinear_rgb_sampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_rgb_sampler_unit: bilinear RGB888 sampler, clamp-to-edge
// Holds an RGB image in four parity banks and blends four corners per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item transfers at a rising edge with start high and busy
//   low. in_cmd selects a pixel write (in_write_* fields) or a sample at
//   (in_sample_x, in_sample_y), signed fixed point with FRAC_BITS fraction
//   bits in texel-centre convention.
//   Result channel: each sample gives one result on out_red/green/blue with
//   out_valid high for exactly one cycle; writes give no result.
//   A sample passes the stage 1 registers, the bank read and stage 2
//   registers, then stages 3 and 4 and the output register. Throughput: one
//   item every cycle while busy is low, set by the read of the four banks
//   (even/odd column by even/odd row), which hands all four corners of any
//   sample out at once. Configuration: cfg_we writes image_width (index 0) or
//   image_height (index 1); write only while the pipeline is empty.
//   Reset: synchronous, clears the pipeline and sets both sizes to 512; busy
//   is high while reset is applied and for the cycle after. The pixel store is
//   not cleared; a sample must only touch pixels that were written.
//   The receiver cannot stall, so busy never rises outside reset.
// ----------------------------------------------------------------------------
module bilinear_rgb_sampler_unit
  import brs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [COORD_W-1:0]   in_write_col,
  input  logic [COORD_W-1:0]   in_write_row,
  input  logic [CHAN_W-1:0]    in_write_red,
  input  logic [CHAN_W-1:0]    in_write_green,
  input  logic [CHAN_W-1:0]    in_write_blue,
  input  logic signed [POS_W-1:0] in_sample_x,
  input  logic signed [POS_W-1:0] in_sample_y,
  output logic                 out_valid,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int F      = FRAC_BITS;
  localparam int FLW    = POS_W + 1 - F;          // floor width
  localparam int WT_W   = F + 1;                   // per-axis weight
  localparam int WW_W   = 2 * WT_W;                // corner weight
  localparam int PROD_W = WW_W + CHAN_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RES_W  = SUM_W - 2 * F;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int XCW    = (FLW + 1 > XW + 1) ? FLW + 1 : XW + 1;
  localparam int YCW    = (FLW + 1 > YW + 1) ? FLW + 1 : YW + 1;
  localparam int XSW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int YSW    = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int BANK_W = (MAX_WIDTH + 1) / 2;
  localparam int BANK_H = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH  = BANK_W * BANK_H;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [WT_W-1:0] ONE_WT  = WT_W'(1) << F;
  localparam logic [POS_W:0]  HALF_WT = (POS_W + 1)'(1) << (F - 1);
  localparam logic [SUM_W-1:0] ROUND_C = SUM_W'(1) << (2 * F - 1);

  // last valid index for a size register value
  function automatic logic [XW-1:0] last_x(input logic [CFG_W-1:0] v);
    logic [XSW-1:0] ve;
    ve = XSW'(v);
    if (v == '0) return '0;
    else if (ve > XSW'(MAX_WIDTH)) return XW'(MAX_WIDTH - 1);
    else return XW'(ve - XSW'(1));
  endfunction

  function automatic logic [YW-1:0] last_y(input logic [CFG_W-1:0] v);
    logic [YSW-1:0] ve;
    ve = YSW'(v);
    if (v == '0) return '0;
    else if (ve > YSW'(MAX_HEIGHT)) return YW'(MAX_HEIGHT - 1);
    else return YW'(ve - YSW'(1));
  endfunction

  function automatic logic [XW-1:0] clamp_x(input logic signed [XCW-1:0] v,
                                            input logic [XW-1:0] last);
    logic signed [XCW-1:0] le;
    le = $signed(XCW'(last));
    if (v < 0) return '0;
    else if (v > le) return last;
    else return XW'(v);
  endfunction

  function automatic logic [YW-1:0] clamp_y(input logic signed [YCW-1:0] v,
                                            input logic [YW-1:0] last);
    logic signed [YCW-1:0] le;
    le = $signed(YCW'(last));
    if (v < 0) return '0;
    else if (v > le) return last;
    else return YW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // configuration, held as last valid index per axis
  // --------------------------------------------------------------------------
  logic [XW-1:0] last_x_r;
  logic [YW-1:0] last_y_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= last_x(SIZE_RESET);
      last_y_r <= last_y(SIZE_RESET);
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  last_x_r <= last_x(cfg_data);
          REG_IMAGE_HEIGHT: last_y_r <= last_y(cfg_data);
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r | ~rst_n;

  logic in_xfer;
  assign in_xfer = start & ~busy;

  // --------------------------------------------------------------------------
  // stage 1: half-texel offset, floor and fraction
  // --------------------------------------------------------------------------
  logic                    s1_smp_r;
  logic                    s1_wen_r;
  logic [COORD_W-1:0]      s1_wcol_r, s1_wrow_r;
  logic [PIXEL_W-1:0]      s1_wpix_r;
  logic signed [FLW-1:0]   s1_flx_r, s1_fly_r;
  logic [F-1:0]            s1_fx_r, s1_fy_r;

  logic [POS_W:0] px_nxt, py_nxt;

  always_comb begin
    px_nxt = {in_sample_x[POS_W-1], in_sample_x} - HALF_WT;
    py_nxt = {in_sample_y[POS_W-1], in_sample_y} - HALF_WT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r <= 1'b0;
      s1_wen_r <= 1'b0;
    end else begin
      s1_smp_r <= in_xfer && (in_cmd == CMD_SAMPLE);
      // writes outside the store are dropped
      s1_wen_r <= in_xfer && (in_cmd == CMD_WRITE)
                  && (int'(in_write_col) < MAX_WIDTH)
                  && (int'(in_write_row) < MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    s1_wcol_r <= in_write_col;
    s1_wrow_r <= in_write_row;
    s1_wpix_r <= {in_write_red, in_write_green, in_write_blue};
    s1_flx_r  <= $signed(px_nxt[POS_W:F]);
    s1_fly_r  <= $signed(py_nxt[POS_W:F]);
    s1_fx_r   <= px_nxt[F-1:0];
    s1_fy_r   <= py_nxt[F-1:0];
  end

  // --------------------------------------------------------------------------
  // stage 1 logic: clamp corners, axis weights, bank addresses
  // --------------------------------------------------------------------------
  logic [XW-1:0]           xc0, xc1;
  logic [YW-1:0]           yc0, yc1;
  logic [WT_W-1:0]         wx0, wx1, wy0, wy1;
  logic [1:0][WT_W-1:0]    s2_wx_nxt, s2_wy_nxt;
  logic [3:0][AW-1:0]      raddr;
  logic [AW-1:0]           waddr;
  logic [3:0]              bank_we;

  always_comb begin
    logic signed [XCW-1:0] fx_e;
    logic signed [YCW-1:0] fy_e;
    logic [XW-1:0] csel, wc;
    logic [YW-1:0] rsel, wr;
    logic cpar, rpar;
    fx_e = XCW'(s1_flx_r);
    fy_e = YCW'(s1_fly_r);
    xc0  = clamp_x(fx_e, last_x_r);
    xc1  = clamp_x(fx_e + XCW'(1), last_x_r);
    yc0  = clamp_y(fy_e, last_y_r);
    yc1  = clamp_y(fy_e + YCW'(1), last_y_r);

    // both corners on one index: that corner takes the whole weight
    if (xc0 == xc1) begin
      wx0 = ONE_WT;
      wx1 = '0;
    end else begin
      wx0 = ONE_WT - WT_W'(s1_fx_r);
      wx1 = WT_W'(s1_fx_r);
    end
    if (yc0 == yc1) begin
      wy0 = ONE_WT;
      wy1 = '0;
    end else begin
      wy0 = ONE_WT - WT_W'(s1_fy_r);
      wy1 = WT_W'(s1_fy_r);
    end

    // weights sorted by index parity, matching the banks
    for (int p = 0; p < 2; p++) begin
      cpar = 1'(p);
      if (xc0[0] == cpar) s2_wx_nxt[p] = wx0;
      else if (xc1[0] == cpar) s2_wx_nxt[p] = wx1;
      else s2_wx_nxt[p] = '0;
      if (yc0[0] == cpar) s2_wy_nxt[p] = wy0;
      else if (yc1[0] == cpar) s2_wy_nxt[p] = wy1;
      else s2_wy_nxt[p] = '0;
    end

    // bank b holds column parity b[0] and row parity b[1]
    for (int b = 0; b < 4; b++) begin
      cpar = 1'(b);
      rpar = 1'(b >> 1);
      csel = (xc0[0] == cpar) ? xc0 : xc1;
      rsel = (yc0[0] == rpar) ? yc0 : yc1;
      raddr[b] = AW'(AW'(rsel >> 1) * AW'(BANK_W) + AW'(csel >> 1));
    end

    wc = XW'(s1_wcol_r);
    wr = YW'(s1_wrow_r);
    waddr = AW'(AW'(wr >> 1) * AW'(BANK_W) + AW'(wc >> 1));
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = s1_wen_r && (2'(b) == {wr[0], wc[0]});
    end
  end

  // --------------------------------------------------------------------------
  // pixel store: four banks, one write or four reads per cycle
  // --------------------------------------------------------------------------
  logic [PIXEL_W-1:0] mem [4][DEPTH];
  logic [3:0][PIXEL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (bank_we[b]) mem[b][waddr] <= s1_wpix_r;
      if (s1_smp_r) rdata_r[b] <= mem[b][raddr[b]];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: read data and axis weights
  // --------------------------------------------------------------------------
  logic                 s2_vld_r;
  logic [1:0][WT_W-1:0] s2_wx_r, s2_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else s2_vld_r <= s1_smp_r;
  end

  always_ff @(posedge clk) begin
    s2_wx_r <= s2_wx_nxt;
    s2_wy_r <= s2_wy_nxt;
  end

  logic [3:0][WW_W-1:0]    s3_wgt_nxt;
  logic [3:0][PIXEL_W-1:0] s3_pix_nxt;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      s3_wgt_nxt[b] = WW_W'(s2_wx_r[b & 1] * s2_wy_r[b >> 1]);
      // unused corner may hold an unwritten entry
      s3_pix_nxt[b] = (s3_wgt_nxt[b] == '0) ? '0 : rdata_r[b];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: corner weights, channel products
  // --------------------------------------------------------------------------
  logic                    s3_vld_r;
  logic [3:0][WW_W-1:0]    s3_wgt_r;
  logic [3:0][PIXEL_W-1:0] s3_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    s3_wgt_r <= s3_wgt_nxt;
    s3_pix_r <= s3_pix_nxt;
  end

  logic [3:0][2:0][PROD_W-1:0] s4_prod_nxt;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      for (int c = 0; c < 3; c++) begin
        s4_prod_nxt[b][c] = PROD_W'(s3_pix_r[b][c*CHAN_W +: CHAN_W] * s3_wgt_r[b]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: sum, round half up, saturate
  // --------------------------------------------------------------------------
  logic                        s4_vld_r;
  logic [3:0][2:0][PROD_W-1:0] s4_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    s4_prod_r <= s4_prod_nxt;
  end

  logic [2:0][CHAN_W-1:0] chan_nxt;

  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [RES_W-1:0] res;
    for (int c = 0; c < 3; c++) begin
      sum = SUM_W'(s4_prod_r[0][c]) + SUM_W'(s4_prod_r[1][c])
          + SUM_W'(s4_prod_r[2][c]) + SUM_W'(s4_prod_r[3][c]) + ROUND_C;
      res = sum[SUM_W-1:2*F];
      chan_nxt[c] = (res > RES_W'(CHAN_MAX)) ? CHAN_MAX : res[CHAN_W-1:0];
    end
  end

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    out_red_r   <= chan_nxt[2];
    out_green_r <= chan_nxt[1];
    out_blue_r  <= chan_nxt[0];
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_sample_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_cmd == CMD_SAMPLE) |-> ##5 out_valid)
    else $error("sample transfer without a result");

  a_write_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_cmd == CMD_WRITE) |-> ##5 !out_valid)
    else $error("pixel write produced a result");

  a_axis_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ((s2_wx_r[0] + s2_wx_r[1]) == ONE_WT)
                 && ((s2_wy_r[0] + s2_wy_r[1]) == ONE_WT))
    else $error("axis weights do not sum to one");

  a_corner_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (SUM_W'(s3_wgt_r[0]) + SUM_W'(s3_wgt_r[1]) + SUM_W'(s3_wgt_r[2])
                  + SUM_W'(s3_wgt_r[3])) == (SUM_W'(1) << (2 * F)))
    else $error("corner weights do not sum to one");

  a_write_not_during_sample: assert property (@(posedge clk) disable iff (!rst_n)
    s1_smp_r |-> (bank_we == '0))
    else $error("bank write while a sample reads");

endmodule

### verif/bilinear_rgb_sampler_unit_tb.sv
// ----------------------------------------------------------------------------
// bilinear_rgb_sampler_unit_tb: self-checking bench for the bilinear sampler
// Loads pixels and issues sample points in bursts over a series of image sizes.
// Every sample result is checked per channel against a bit-exact predictor.
// ----------------------------------------------------------------------------
module bilinear_rgb_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brs_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;
  localparam int FRAC          = DEF_FRAC_BITS;
  localparam int ONE_FIX       = 1 << FRAC;
  localparam int HALF_FIX      = ONE_FIX / 2;
  localparam int STORE_DEPTH   = MAX_W * MAX_H;
  localparam int PIPE_LATENCY  = 5;
  localparam int SETTLE_CYCLES = 3 * PIPE_LATENCY;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 50;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      row;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } brs_item_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_cmd         = CMD_WRITE;
  logic [COORD_W-1:0]      in_write_col   = '0;
  logic [COORD_W-1:0]      in_write_row   = '0;
  logic [CHAN_W-1:0]       in_write_red   = '0;
  logic [CHAN_W-1:0]       in_write_green = '0;
  logic [CHAN_W-1:0]       in_write_blue  = '0;
  logic signed [POS_W-1:0] in_sample_x    = '0;
  logic signed [POS_W-1:0] in_sample_y    = '0;
  logic                    out_valid;
  logic [CHAN_W-1:0]       out_red;
  logic [CHAN_W-1:0]       out_green;
  logic [CHAN_W-1:0]       out_blue;
  logic                    cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index      = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]        cfg_data       = '0;

  bilinear_rgb_sampler_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_write_col   (in_write_col),
    .in_write_row   (in_write_row),
    .in_write_red   (in_write_red),
    .in_write_green (in_write_green),
    .in_write_blue  (in_write_blue),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor image and the set of pixels the stimulus has already queued a write to
  logic [PIXEL_W-1:0] pix_mem [STORE_DEPTH];
  bit                 pix_planned [STORE_DEPTH];
  logic [CFG_W-1:0]   width_reg  = SIZE_RESET;
  logic [CFG_W-1:0]   height_reg = SIZE_RESET;

  brs_item_t pending_items [$];
  rgb_t      expected_colors [$];
  brs_item_t cur_item;

  int error_count   = 0;
  int write_count   = 0;
  int sample_count  = 0;
  int edge_count    = 0;
  int setting_count = 0;
  int cycle_count   = 0;
  int gap_left      = 0;
  int burst_left    = 8;

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_chan(input string name, input logic [CHAN_W-1:0] got,
                            input logic [CHAN_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic int eff_dim(input logic [CFG_W-1:0] reg_val, input int max_dim);
    if (reg_val == 0) return 1;
    if (int'(reg_val) > max_dim) return max_dim;
    return int'(reg_val);
  endfunction

  // corners and weights along one axis, with clamp to edge
  function automatic void axis_corners(input logic signed [POS_W-1:0] pos, input int dim,
                                       output int idx0, output int idx1,
                                       output int wt0, output int wt1);
    int p;
    int fl;
    int fr;
    p  = int'(pos) - HALF_FIX;
    fl = p >>> FRAC;
    fr = p & (ONE_FIX - 1);
    idx0 = (fl < 0) ? 0 : (fl > dim - 1) ? dim - 1 : fl;
    idx1 = (fl + 1 < 0) ? 0 : (fl + 1 > dim - 1) ? dim - 1 : fl + 1;
    if (idx0 == idx1) begin
      wt0 = ONE_FIX;
      wt1 = 0;
    end else begin
      wt0 = ONE_FIX - fr;
      wt1 = fr;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] round_chan(input int acc);
    int r;
    r = (acc + (1 << (2 * FRAC - 1))) >>> (2 * FRAC);
    return (r > 255) ? CHAN_MAX : r[CHAN_W-1:0];
  endfunction

  function automatic rgb_t predict_color(input logic signed [POS_W-1:0] pos_x,
                                         input logic signed [POS_W-1:0] pos_y);
    int xi [2];
    int xw [2];
    int yi [2];
    int yw [2];
    int acc_r;
    int acc_g;
    int acc_b;
    int wgt;
    logic [PIXEL_W-1:0] px;
    rgb_t res;
    axis_corners(pos_x, eff_dim(width_reg, MAX_W), xi[0], xi[1], xw[0], xw[1]);
    axis_corners(pos_y, eff_dim(height_reg, MAX_H), yi[0], yi[1], yw[0], yw[1]);
    if (xi[0] == xi[1] || yi[0] == yi[1]) edge_count++;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        px  = pix_mem[yi[j] * MAX_W + xi[i]];
        wgt = xw[i] * yw[j];
        acc_r += int'(px[PIXEL_W-1 -: CHAN_W]) * wgt;
        acc_g += int'(px[2*CHAN_W-1 -: CHAN_W]) * wgt;
        acc_b += int'(px[CHAN_W-1:0]) * wgt;
      end
    end
    res.red   = round_chan(acc_r);
    res.green = round_chan(acc_g);
    res.blue  = round_chan(acc_b);
    return res;
  endfunction

  // unused fields get random content too
  function automatic brs_item_t rand_item();
    brs_item_t it;
    it.cmd   = CMD_WRITE;
    it.col   = COORD_W'($urandom);
    it.row   = COORD_W'($urandom);
    it.red   = CHAN_W'($urandom);
    it.green = CHAN_W'($urandom);
    it.blue  = CHAN_W'($urandom);
    it.pos_x = POS_W'($urandom);
    it.pos_y = POS_W'($urandom);
    return it;
  endfunction

  task automatic queue_write(input int col, input int row, input logic [PIXEL_W-1:0] rgb);
    brs_item_t it;
    it = rand_item();
    it.cmd = CMD_WRITE;
    it.col = COORD_W'(col);
    it.row = COORD_W'(row);
    {it.red, it.green, it.blue} = rgb;
    pending_items.push_back(it);
    pix_planned[row * MAX_W + col] = 1'b1;
  endtask

  // a sample is preceded by writes to any of its four corners not yet queued for a write
  task automatic queue_sample(input int pos_x, input int pos_y);
    brs_item_t it;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    int cx [2];
    int cy [2];
    int wx0;
    int wx1;
    int wy0;
    int wy1;
    sx = POS_W'(pos_x);
    sy = POS_W'(pos_y);
    axis_corners(sx, eff_dim(width_reg, MAX_W), cx[0], cx[1], wx0, wx1);
    axis_corners(sy, eff_dim(height_reg, MAX_H), cy[0], cy[1], wy0, wy1);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!pix_planned[cy[j] * MAX_W + cx[i]]) begin
          queue_write(cx[i], cy[j], PIXEL_W'($urandom));
        end
      end
    end
    it = rand_item();
    it.cmd   = CMD_SAMPLE;
    it.pos_x = sx;
    it.pos_y = sy;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || start || expected_colors.size() != 0) begin
      @(negedge clk);
    end
    // a trailing pixel write may still be in the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                           input int n_items);
    int w;
    int h;
    int span_x;
    int span_y;
    int org_x;
    int org_y;
    int pick;
    wait_idle();
    set_size(REG_IMAGE_WIDTH, w_val);
    set_size(REG_IMAGE_HEIGHT, h_val);
    setting_count++;
    w = eff_dim(w_val, MAX_W);
    h = eff_dim(h_val, MAX_H);
    span_x = (w < 16) ? w : 16;
    span_y = (h < 16) ? h : 16;
    org_x = $urandom_range(0, w - span_x);
    org_y = $urandom_range(0, h - span_y);
    for (int k = 0; k < n_items; k++) begin
      // halfway through, hold the sender until every result is back
      if (k == n_items / 2) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queue_write($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1),
                    PIXEL_W'($urandom));
      end else if (pick < 22) begin
        queue_write(org_x + $urandom_range(0, span_x - 1),
                    org_y + $urandom_range(0, span_y - 1), PIXEL_W'($urandom));
      end else if (pick < 32) begin
        queue_sample((org_x + $urandom_range(0, span_x - 1)) * ONE_FIX + HALF_FIX,
                     (org_y + $urandom_range(0, span_y - 1)) * ONE_FIX + HALF_FIX);
      end else if (pick < 47) begin
        queue_sample($urandom, $urandom);
      end else begin
        queue_sample(org_x * ONE_FIX - 3 * HALF_FIX + $urandom_range(0, (span_x + 2) * ONE_FIX),
                     org_y * ONE_FIX - 3 * HALF_FIX + $urandom_range(0, (span_y + 2) * ONE_FIX));
      end
    end
  endtask

  // driver: bursts of transfers with random gaps, predicts on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_item.cmd == CMD_WRITE) begin
          pix_mem[cur_item.row * MAX_W + cur_item.col] =
            {cur_item.red, cur_item.green, cur_item.blue};
          write_count++;
        end else begin
          expected_colors.push_back(predict_color(cur_item.pos_x, cur_item.pos_y));
          sample_count++;
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_cmd         <= cur_item.cmd;
          in_write_col   <= cur_item.col;
          in_write_row   <= cur_item.row;
          in_write_red   <= cur_item.red;
          in_write_green <= cur_item.green;
          in_write_blue  <= cur_item.blue;
          in_sample_x    <= cur_item.pos_x;
          in_sample_y    <= cur_item.pos_y;
          start          <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest predicted color
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_colors.size() == 0) begin
        report_error("result with no sample outstanding");
      end else begin
        want = expected_colors.pop_front();
        check_chan("red", out_red, want.red);
        check_chan("green", out_green, want.green);
        check_chan("blue", out_blue, want.blue);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_colors.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset sizes
    queue_write(0, 0, 24'h000000);
    queue_write(1, 0, 24'hffffff);
    queue_write(0, 1, 24'hff0080);
    queue_write(1, 1, 24'h00ff01);
    queue_write(511, 511, 24'hffffff);
    queue_write(511, 0, 24'h804020);
    queue_write(0, 511, 24'h010203);
    queue_write(510, 511, 24'hc86432);
    queue_write(511, 510, 24'h7f80fe);
    queue_write(510, 510, 24'h55aa33);
    queue_sample(128, 128);             // exact texel centre
    queue_sample(256, 256);             // even blend of four corners
    queue_sample(200, 330);
    queue_sample(0, 0);                 // left of the first centre, corners clamp together
    queue_sample(-524288, -524288);
    queue_sample(524287, 524287);
    queue_sample(524287, -524288);
    queue_sample(-524288, 524287);
    queue_sample(511 * 256, 510 * 256 + 200);
    queue_sample(510 * 256 + 127, 511 * 256 + 128);

    // corner loads come on top of the items drawn per phase
    run_phase(10'd1, 10'd1, 32);
    run_phase(10'd0, 10'd0, 32);        // zero acts as one
    run_phase(10'd2, 10'd3, 32);
    run_phase(10'd512, 10'd512, 32);
    run_phase(10'd1023, 10'd513, 32);   // above the maximum acts as the maximum
    run_phase(10'd7, 10'd1, 32);
    run_phase(10'd1, 10'd9, 32);
    run_phase(10'd16, 10'd16, 32);
    run_phase(10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)), 32);
    run_phase(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 32);
    run_phase(10'd300, 10'd512, 32);
    wait_idle();

    $display("covered %0d pixel writes and %0d samples (%0d with an axis clamped to one corner)",
             write_count, sample_count, edge_count);
    $display("over %0d size settings, including zero, one, the maximum and beyond it",
             setting_count + 1);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
